@@ sv/dfiir_pkg.sv @@
// Package for the direct-form-I IIR filter.
// Sizes, item and register codes, tap cell and MAC control types shared by all filter modules.
// No dependencies.
package dfiir_pkg;

	localparam int MAX_ORDER      = 8;
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_FRAC_BITS = 24;

	localparam int TAPS      = MAX_ORDER + 1;
	localparam int COEF_BITS = 32;
	localparam int FUNC_BITS = 2;
	localparam int IDX_BITS  = 4;
	localparam int ORD_BITS  = 4;
	localparam int CFG_DATA_W = 4;
	localparam int CFG_IDX_W  = 1;

	// one forward and one feedback product per tap
	localparam int CNT_W = $clog2(2 * TAPS);
	localparam int TAP_W = CNT_W - 1;

	localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
	// headroom for 2*TAPS products plus the rounding half
	localparam int ACC_BITS  = PROD_BITS + CNT_W + 1;

	// slave tdata: sample_in, coef_index, coef_value, zero padded to bytes
	localparam int SMP_LSB   = 0;
	localparam int IDX_LSB   = SMP_LSB + SAMPLE_BITS;
	localparam int COEF_LSB  = IDX_LSB + IDX_BITS;
	localparam int S_FIELD_W = COEF_LSB + COEF_BITS;
	localparam int S_DATA_W  = ((S_FIELD_W + 7) / 8) * 8;
	localparam int M_DATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

	// item kinds carried in slave tuser
	typedef enum logic [FUNC_BITS-1:0] {
		FN_SAMPLE = 2'd0,
		FN_FWD    = 2'd1,
		FN_FB     = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	// config register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORDER = 1'b0,
		REG_FB_EN = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] x;  // input history entry
		logic signed [SAMPLE_BITS-1:0] y;  // output history entry
		logic signed [COEF_BITS-1:0]   b;  // forward coefficient
		logic signed [COEF_BITS-1:0]   a;  // feedback coefficient
	} cell_data_t;

	typedef struct packed {
		logic clear;
		logic shift;
		logic rotate;
		logic load_fwd;
		logic load_fb;
	} cell_ctrl_t;

	typedef struct packed {
		logic start;     // clear accumulator
		logic valid;     // operands presented this cycle
		logic use_prod;  // tap in use, else adds zero
	} mac_ctrl_t;

endpackage

@@ sv/direct_form_iir_filter.sv @@
// Top level of the direct-form-I IIR filter: ring of tap cells and one shared MAC.
// Depends on dfiir_pkg, dfiir_cell and dfiir_mac.
//
// Usage:
//  - Slave stream carries one item per handshake; tuser is func (0 filter sample,
//    1 write forward coefficient, 2 write feedback coefficient, 3 clear histories).
//  - Coefficient writes and history clears take effect at the accepting edge and
//    give no result; tready stays high for them.
//  - A sample item shifts the histories, then the tap ring rotates one place after
//    each tap passes cell 0, where the MAC takes the forward product and then the
//    feedback product of that tap; the sequencer then steps through a drain state
//    and a result state. The block takes no new item until the result is stored;
//    the ring is back in place when the result is formed.
//  - Results sit in an output register; the next item is accepted while the
//    receiver stalls, and a finished sample waits in the result cycle only if the
//    previous result has still not been taken.
//  - Saturated results carry tuser high and leave the newest stored output equal
//    to the previous one.
//  - Config port: index 0 filter_order, index 1 feedback_enable; always ready.
//  - Reset clears histories and coefficients, sets order 2 with feedback on.
module direct_form_iir_filter import dfiir_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [S_DATA_W-1:0]   s_axis_tdata,   // sample_in, coef_index, coef_value, pad
	input  logic [FUNC_BITS-1:0]  s_axis_tuser,   // func
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [M_DATA_W-1:0]   m_axis_tdata,   // sample_out
	output logic                  m_axis_tuser,   // overflowed
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              cnt_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic                          out_ovf_q;
	logic [ORD_BITS-1:0]           filter_order_q;
	logic                          fb_en_q;

	func_t                         func;
	logic                          s_fire;
	logic                          out_free;
	logic                          phase;
	logic [TAP_W-1:0]              tap;
	logic [TAP_W-1:0]              ord_use;
	logic signed [SAMPLE_BITS-1:0] smp;
	logic [IDX_BITS-1:0]           cidx;
	logic signed [COEF_BITS-1:0]   cval;
	logic signed [SAMPLE_BITS-1:0] mac_res;
	logic                          mac_ovf;
	logic                          write_y;
	cell_ctrl_t                    cctrl;
	mac_ctrl_t                     mctrl;
	cell_data_t                    cells [TAPS];
	logic signed [SAMPLE_BITS-1:0] opd_x;
	logic signed [COEF_BITS-1:0]   opd_c;
	logic                          fwd_use, fb_use;

	assign func     = func_t'(s_axis_tuser);
	assign smp      = s_axis_tdata[IDX_LSB-1:SMP_LSB];
	assign cidx     = s_axis_tdata[COEF_LSB-1:IDX_LSB];
	assign cval     = s_axis_tdata[S_FIELD_W-1:COEF_LSB];
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire   = s_axis_tvalid & s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// step counter: low bit picks forward/feedback, upper bits the tap in cell 0
	assign phase = cnt_q[0];
	assign tap   = cnt_q[CNT_W-1:1];
	assign ord_use = (32'(filter_order_q) > MAX_ORDER) ? TAP_W'(MAX_ORDER)
	                                                   : TAP_W'(filter_order_q);

	// config registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_order_q <= ORD_BITS'(2);
			fb_en_q        <= 1'b1;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ORDER: filter_order_q <= cfg_data[ORD_BITS-1:0];
				REG_FB_EN: fb_en_q        <= cfg_data[0];
				default:   ;
			endcase
		end
	end

	// cell controls
	assign write_y        = (state_q == ST_DONE) && out_free && !mac_ovf;
	assign cctrl.rotate   = (state_q == ST_RUN) && phase;
	assign cctrl.shift    = s_fire && (func == FN_SAMPLE);
	assign cctrl.clear    = s_fire && (func == FN_CLEAR);
	assign cctrl.load_fwd = s_fire && (func == FN_FWD);
	assign cctrl.load_fb  = s_fire && (func == FN_FB);

	// ring: histories shift to older taps, rotation pulls from the next cell
	for (genvar i = 0; i < TAPS; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] x_in, y_in;
		if (i == 0) begin : g_head
			assign x_in = smp;
			assign y_in = cells[0].y;  // newest output duplicates until written
		end else begin : g_body
			assign x_in = cells[i-1].x;
			assign y_in = cells[i-1].y;
		end
		dfiir_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (cctrl),
			.tap_sel (32'(cidx) == i),
			.wr_y    ((i == 0) && write_y),
			.x_in    (x_in),
			.y_in    (y_in),
			.y_new   (mac_res),
			.coef    (cval),
			.rot_in  (cells[(i + 1) % TAPS]),
			.tap_out (cells[i])
		);
	end

	// MAC operands from the head cell
	assign fwd_use = (tap <= ord_use);
	assign fb_use  = fb_en_q && (tap != '0) && (tap <= ord_use);
	assign opd_x   = phase ? cells[0].y : cells[0].x;
	assign opd_c   = phase ? cells[0].a : cells[0].b;

	assign mctrl.start    = cctrl.shift;
	assign mctrl.valid    = (state_q == ST_RUN);
	assign mctrl.use_prod = (state_q == ST_RUN) && (phase ? fb_use : fwd_use);

	dfiir_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mctrl),
		.opd_x  (opd_x),
		.opd_c  (opd_c),
		.res    (mac_res),
		.ovf    (mac_ovf)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_ovf_q   <= 1'b0;
		end else begin
			// new result loads, otherwise a taken one leaves
			if ((state_q == ST_DONE) && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cctrl.shift) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(2 * TAPS - 1))
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: state_q <= ST_DONE;
				ST_DONE: begin
					if (out_free) begin
						out_data_q  <= mac_res;
						out_ovf_q   <= mac_ovf;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_DATA_W'(out_data_q);
	assign m_axis_tuser  = out_ovf_q;

	// a sample item starts the ring at its first step
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && (func == FN_SAMPLE)) |=> (state_q == ST_RUN) && (cnt_q == '0))
		else $error("ring did not start on sample item");

	// leaving the result cycle always presents a result
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && out_free) |=> m_axis_tvalid && (state_q == ST_IDLE))
		else $error("result lost at end of sample");

	// a flagged result sits at one of the sample limits
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |->
			((out_data_q == SAMPLE_MAX) || (out_data_q == SAMPLE_MIN)))
		else $error("overflow flag on unsaturated result");

	// no item is taken while the ring is rotating
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> !s_fire && !write_y)
		else $error("item accepted during rotation");

endmodule

@@ sv/dfiir_cell.sv @@
// One tap cell of the filter ring: history pair and coefficient pair.
// Shifts histories towards older taps, rotates everything one place for the MAC.
// Depends on dfiir_pkg.
module dfiir_cell import dfiir_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cell_ctrl_t                    ctrl,
	input  logic                          tap_sel,
	input  logic                          wr_y,
	input  logic signed [SAMPLE_BITS-1:0] x_in,
	input  logic signed [SAMPLE_BITS-1:0] y_in,
	input  logic signed [SAMPLE_BITS-1:0] y_new,
	input  logic signed [COEF_BITS-1:0]   coef,
	input  cell_data_t                    rot_in,
	output cell_data_t                    tap_out
);

	cell_data_t cell_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else if (ctrl.rotate) begin
			cell_q <= rot_in;
		end else if (ctrl.shift) begin
			cell_q.x <= x_in;
			cell_q.y <= y_in;
		end else if (ctrl.clear) begin
			cell_q.x <= '0;
			cell_q.y <= '0;
		end else begin
			if (wr_y)
				cell_q.y <= y_new;
			if (ctrl.load_fwd && tap_sel)
				cell_q.b <= coef;
			if (ctrl.load_fb && tap_sel)
				cell_q.a <= coef;
		end
	end

	assign tap_out = cell_q;

endmodule

@@ sv/dfiir_mac.sv @@
// Shared multiply-accumulate for the filter, with rounding and saturation.
// Product registered, then summed; result formed from the accumulator register.
// Depends on dfiir_pkg.
module dfiir_mac import dfiir_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mac_ctrl_t                     ctrl,
	input  logic signed [SAMPLE_BITS-1:0] opd_x,
	input  logic signed [COEF_BITS-1:0]   opd_c,
	output logic signed [SAMPLE_BITS-1:0] res,
	output logic                          ovf
);

	localparam logic signed [ACC_BITS-1:0] ACC_MAX = ACC_BITS'(SAMPLE_MAX);
	localparam logic signed [ACC_BITS-1:0] ACC_MIN = ACC_BITS'(SAMPLE_MIN);

	logic signed [PROD_BITS-1:0] prod;
	logic signed [PROD_BITS-1:0] prod_s1;
	logic                        vld_s1;
	logic signed [ACC_BITS-1:0]  acc_q;
	logic signed [ACC_BITS-1:0]  sum;
	logic signed [ACC_BITS-1:0]  rnd;
	logic                        hi, lo;

	// signed product, kept apart from the zero select
	assign prod = opd_x * opd_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= ctrl.valid;
			if (ctrl.start)
				acc_q <= '0;
			else if (vld_s1)
				acc_q <= acc_q + ACC_BITS'(prod_s1);
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ctrl.use_prod ? prod : '0;
	end

	// round half up, then clamp to the sample range
	assign sum = acc_q + $signed(ROUND_HALF);
	assign rnd = sum >>> COEF_FRAC_BITS;
	assign hi  = rnd > ACC_MAX;
	assign lo  = rnd < ACC_MIN;
	assign ovf = hi | lo;
	assign res = hi ? SAMPLE_MAX : (lo ? SAMPLE_MIN : rnd[SAMPLE_BITS-1:0]);

endmodule

@@ tb/tb_direct_form_iir_filter.sv @@
// Self-checking testbench for direct_form_iir_filter: directed stimulus rows, then random
// phases over several order and feedback settings, checked against an in-bench predictor.
// Depends on dfiir_pkg and the filter RTL.
module tb_direct_form_iir_filter import dfiir_pkg::*; ();

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] smp;
		logic                          ovf;
	} filtered_t;

	typedef struct packed {
		func_t                  func;
		logic [SAMPLE_BITS-1:0] smp;
		logic [IDX_BITS-1:0]    idx;
		logic [COEF_BITS-1:0]   coef;
		logic                   typed;     // expected result written into the row
		logic [SAMPLE_BITS-1:0] want_smp;
		logic                   want_ovf;
	} stim_row_t;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int SETTLE       = 30;      // a sample item keeps the block busy
	localparam int PHASES       = 9;
	localparam int PHASE_ITEMS  = 170;
	localparam int N_ROWS       = 26;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata = '0;   // sample_in, coef_index, coef_value, pad
	logic [FUNC_BITS-1:0]  s_axis_tuser = '0;   // func
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;        // sample_out
	logic                  m_axis_tuser;        // overflowed
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	direct_form_iir_filter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Filter state as the block should hold it; index 0 is the newest history entry.
	logic signed [SAMPLE_BITS-1:0] x_hist [TAPS];
	logic signed [SAMPLE_BITS-1:0] y_hist [TAPS];
	logic signed [COEF_BITS-1:0]   b_coef [TAPS];
	logic signed [COEF_BITS-1:0]   a_coef [TAPS];
	logic [ORD_BITS-1:0]           order_reg;
	logic                          feedback_reg;

	filtered_t   pending_results[$];
	int          mismatch_count = 0;
	int          checked_count  = 0;
	int          n_samples      = 0;
	int          n_saturated    = 0;
	int          n_coef_loads   = 0;
	int          n_clears       = 0;
	int          snd_idle_pct   = 0;
	int          rcv_idle_pct   = 0;
	int unsigned cycle_count    = 0;

	// Order and feedback per random phase: extremes, out-of-range orders and FIR runs.
	int phase_order    [PHASES] = '{0, 8, 15, 1, 5, 9, 3, 8, 2};
	int phase_feedback [PHASES] = '{0, 1, 1, 0, 1, 0, 1, 0, 1};

	// Directed rows. Typed expectations only where the sum reduces to one tap.
	stim_row_t directed_rows [N_ROWS] = '{
		// zero coefficients after reset: everything rounds to zero
		'{FN_SAMPLE, 16'h7FFF, 4'd0,  32'h0000_0000, 1'b1, 16'h0000, 1'b0},
		'{FN_SAMPLE, 16'h8000, 4'd0,  32'h0000_0000, 1'b1, 16'h0000, 1'b0},
		// unity forward tap 0: sample passes through
		'{FN_FWD,    16'h0000, 4'd0,  32'h0100_0000, 1'b0, 16'h0000, 1'b0},
		'{FN_SAMPLE, 16'h3039, 4'd0,  32'h0000_0000, 1'b1, 16'h3039, 1'b0},
		'{FN_SAMPLE, 16'h7FFF, 4'd0,  32'h0000_0000, 1'b1, 16'h7FFF, 1'b0},
		'{FN_SAMPLE, 16'h8000, 4'd0,  32'h0000_0000, 1'b1, 16'h8000, 1'b0},
		// gain one half: round half up
		'{FN_FWD,    16'h0000, 4'd0,  32'h0080_0000, 1'b0, 16'h0000, 1'b0},
		'{FN_SAMPLE, 16'h0001, 4'd0,  32'h0000_0000, 1'b1, 16'h0001, 1'b0},
		'{FN_SAMPLE, 16'hFFFF, 4'd0,  32'h0000_0000, 1'b1, 16'h0000, 1'b0},
		'{FN_SAMPLE, 16'h0003, 4'd0,  32'h0000_0000, 1'b1, 16'h0002, 1'b0},
		// largest and smallest coefficient: saturation both ways
		'{FN_FWD,    16'h0000, 4'd0,  32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0},
		'{FN_SAMPLE, 16'h7FFF, 4'd0,  32'h0000_0000, 1'b1, 16'h7FFF, 1'b1},
		'{FN_SAMPLE, 16'h8000, 4'd0,  32'h0000_0000, 1'b1, 16'h8000, 1'b1},
		'{FN_FWD,    16'h0000, 4'd0,  32'h8000_0000, 1'b0, 16'h0000, 1'b0},
		'{FN_SAMPLE, 16'h7FFF, 4'd0,  32'h0000_0000, 1'b1, 16'h8000, 1'b1},
		'{FN_SAMPLE, 16'h0000, 4'd0,  32'h0000_0000, 1'b1, 16'h0000, 1'b0},
		// tap index past the end is dropped; feedback tap 0 is never used
		'{FN_FWD,    16'h0000, 4'd15, 32'h1234_5678, 1'b0, 16'h0000, 1'b0},
		'{FN_FB,     16'h0000, 4'd0,  32'h7FFF_FFFF, 1'b0, 16'h0000, 1'b0},
		'{FN_FWD,    16'h0000, 4'd0,  32'h0100_0000, 1'b0, 16'h0000, 1'b0},
		'{FN_SAMPLE, 16'h1234, 4'd0,  32'h0000_0000, 1'b1, 16'h1234, 1'b0},
		// real feedback, a history clear, then overflow holds the old output
		'{FN_FWD,    16'h0000, 4'd1,  32'h0080_0000, 1'b0, 16'h0000, 1'b0},
		'{FN_FB,     16'h0000, 4'd1,  32'h0040_0000, 1'b0, 16'h0000, 1'b0},
		'{FN_CLEAR,  16'h0000, 4'd0,  32'h0000_0000, 1'b0, 16'h0000, 1'b0},
		'{FN_SAMPLE, 16'h7FFF, 4'd0,  32'h0000_0000, 1'b0, 16'h0000, 1'b0},
		'{FN_SAMPLE, 16'h7FFF, 4'd0,  32'h0000_0000, 1'b0, 16'h0000, 1'b0},
		'{FN_SAMPLE, 16'h0000, 4'd0,  32'h0000_0000, 1'b0, 16'h0000, 1'b0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls at random
	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_results.size());
			$display("direct_form_iir_filter regression: fail");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		if (mismatch_count < 10)
			$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	function automatic void reset_filter_state();
		order_reg    = 4'd2;
		feedback_reg = 1'b1;
		for (int i = 0; i < TAPS; i++) begin
			x_hist[i] = '0;
			y_hist[i] = '0;
			b_coef[i] = '0;
			a_coef[i] = '0;
		end
	endfunction

	// Shift the histories, run the MAC sum, round and saturate.
	// With 17 products of at most 2^46 the 64-bit sum cannot overflow.
	function automatic filtered_t filter_sample(input logic signed [SAMPLE_BITS-1:0] smp);
		longint    acc;
		longint    rounded;
		int        taps_used;
		filtered_t res;
		taps_used = (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
		for (int i = TAPS - 1; i > 0; i--) begin
			x_hist[i] = x_hist[i-1];
			y_hist[i] = y_hist[i-1];
		end
		x_hist[0] = smp;
		acc = 0;
		for (int i = 0; i <= taps_used; i++)
			acc += longint'(x_hist[i]) * longint'(b_coef[i]);
		if (feedback_reg) begin
			for (int i = 1; i <= taps_used; i++)
				acc += longint'(y_hist[i]) * longint'(a_coef[i]);
		end
		acc += longint'(1) << (COEF_FRAC_BITS - 1);
		rounded = acc >>> COEF_FRAC_BITS;
		res.ovf = 1'b1;
		if (rounded > longint'(SAMPLE_MAX))
			res.smp = SAMPLE_MAX;
		else if (rounded < longint'(SAMPLE_MIN))
			res.smp = SAMPLE_MIN;
		else begin
			res.smp = rounded[SAMPLE_BITS-1:0];
			res.ovf = 1'b0;
		end
		// saturated result is not fed back: newest output repeats the previous one
		y_hist[0] = res.ovf ? y_hist[1] : res.smp;
		return res;
	endfunction

	// Present one item, hold it until taken, then update the predicted state.
	// Valid stays high between back-to-back items.
	task automatic send_item(input func_t func, input logic [SAMPLE_BITS-1:0] smp,
			input logic [IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] coef);
		filtered_t res;
		if ($urandom_range(99) < snd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= S_DATA_W'({coef, idx, smp});
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		unique case (func)
			FN_SAMPLE: begin
				res = filter_sample(smp);
				pending_results.push_back(res);
				n_samples++;
				if (res.ovf)
					n_saturated++;
			end
			FN_FWD, FN_FB: begin
				if (idx <= MAX_ORDER) begin
					if (func == FN_FWD)
						b_coef[idx] = coef;
					else
						a_coef[idx] = coef;
				end
				n_coef_loads++;
			end
			FN_CLEAR: begin
				for (int i = 0; i < TAPS; i++) begin
					x_hist[i] = '0;
					y_hist[i] = '0;
				end
				n_clears++;
			end
		endcase
	endtask

	// Sender stops until every predicted result has been taken.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Both registers in one burst; upper bits of the feedback write are don't-care.
	task automatic set_filter_mode(input int order, input int feedback);
		cfg_valid <= 1'b1;
		cfg_index <= REG_ORDER;
		cfg_data  <= CFG_DATA_W'(order);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		order_reg = CFG_DATA_W'(order);
		cfg_index <= REG_FB_EN;
		cfg_data  <= {3'($urandom), 1'(feedback)};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		feedback_reg = 1'(feedback);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2, 3:    return SAMPLE_BITS'(int'($urandom_range(2047)) - 1024);
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// style 0: gentle taps that mostly stay in range, 1: any value, 2: sparse unity-scale
	function automatic logic [COEF_BITS-1:0] pick_coef(input int style, input bit feedback);
		case (style)
			0:
				if (feedback)
					return COEF_BITS'(int'($urandom_range(1 << 22)) - (1 << 21));
				else
					return COEF_BITS'(int'($urandom_range(1 << 23)) - (1 << 22));
			1:       return COEF_BITS'($urandom);
			default:
				if ($urandom_range(2) == 0)
					return COEF_BITS'(int'($urandom_range(1 << 25)) - (1 << 24));
				else
					return '0;
		endcase
	endfunction

	// Full coefficient set, then mostly samples with loads and clears mixed in.
	task automatic run_phase(input int n_items, input bit pause_midway);
		int    style;
		int    pick;
		func_t fn;
		style = $urandom_range(2);
		for (int t = 0; t < TAPS; t++) begin
			send_item(FN_FWD, SAMPLE_BITS'($urandom), IDX_BITS'(t), pick_coef(style, 1'b0));
			send_item(FN_FB, SAMPLE_BITS'($urandom), IDX_BITS'(t), pick_coef(style, 1'b1));
		end
		for (int k = 2 * TAPS; k < n_items; k++) begin
			if (pause_midway && k == n_items / 2)
				drain_results();
			pick = $urandom_range(99);
			if (pick < 84)
				send_item(FN_SAMPLE, pick_sample(), IDX_BITS'($urandom), COEF_BITS'($urandom));
			else if (pick < 94) begin
				fn = pick[0] ? FN_FWD : FN_FB;
				send_item(fn, SAMPLE_BITS'($urandom), IDX_BITS'($urandom_range(15)),
					pick_coef($urandom_range(2), fn == FN_FB));
			end else
				send_item(FN_CLEAR, SAMPLE_BITS'($urandom), IDX_BITS'($urandom),
					COEF_BITS'($urandom));
		end
	endtask

	// Result checker: oldest prediction against each item taken from the master side.
	always @(posedge clk) begin
		filtered_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0)
				flag_mismatch($sformatf("unexpected result %0d (overflowed %b)",
					$signed(m_axis_tdata[SAMPLE_BITS-1:0]), m_axis_tuser));
			else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.smp)
					flag_mismatch($sformatf("result %0d sample_out expected %0d, got %0d",
						checked_count, want.smp, $signed(m_axis_tdata[SAMPLE_BITS-1:0])));
				if (m_axis_tuser !== want.ovf)
					flag_mismatch($sformatf("result %0d overflowed expected %b, got %b",
						checked_count, want.ovf, m_axis_tuser));
			end
			checked_count++;
		end
	end

	initial begin
		reset_filter_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed rows
		snd_idle_pct = 36;
		rcv_idle_pct = 49;
		for (int r = 0; r < N_ROWS; r++) begin
			send_item(directed_rows[r].func, directed_rows[r].smp, directed_rows[r].idx,
				directed_rows[r].coef);
			// typed value replaces the prediction just queued
			if (directed_rows[r].typed)
				pending_results[pending_results.size() - 1] =
					'{directed_rows[r].want_smp, directed_rows[r].want_ovf};
		end
		drain_results();
		repeat (SETTLE) @(posedge clk);

		// random phases; idling: receiver-heavy, sender-heavy, then none
		for (int p = 0; p < PHASES; p++) begin
			case (p / 3)
				0: begin
					snd_idle_pct = 36;
					rcv_idle_pct = 49;
				end
				1: begin
					snd_idle_pct = 49;
					rcv_idle_pct = 36;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			set_filter_mode(phase_order[p], phase_feedback[p]);
			run_phase(PHASE_ITEMS, p == 4);
			drain_results();
			repeat (SETTLE) @(posedge clk);
		end

		if (pending_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
		$display("covered %0d samples (%0d saturated), %0d coefficient loads, %0d clears",
			n_samples, n_saturated, n_coef_loads, n_clears);
		$display("over %0d order/feedback settings; %0d results checked, %0d mismatches",
			PHASES + 1, checked_count, mismatch_count);
		if (mismatch_count == 0)
			$display("direct_form_iir_filter regression: pass");
		else
			$display("direct_form_iir_filter regression: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/dfiir_pkg.sv
sv/dfiir_cell.sv
sv/dfiir_mac.sv
sv/direct_form_iir_filter.sv
tb/tb_direct_form_iir_filter.sv
